>>> hdl/dhno_pkg.sv
`timescale 1ns / 1ps

package dhno_pkg;

    localparam int MAX_HITS   = 64;
    localparam int COORD_BITS = 21;
    localparam int SLOT_BITS  = $clog2(MAX_HITS);
    localparam int COUNT_BITS = $clog2(MAX_HITS + 1);
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int DIST_BITS  = SQ_BITS + 1;
    localparam int REQ_BITS   = 2;
    localparam int KIND_BITS  = 2;
    localparam int CFG_BITS   = 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t SAFE_HEIGHT_RESET = coord_t'(5000);
    localparam coord_t DRILL_DEPTH_RESET = coord_t'(-2000);

    localparam logic [CFG_BITS-1:0] CFG_SAFE_HEIGHT = 1'b0;
    localparam logic [CFG_BITS-1:0] CFG_DRILL_DEPTH = 1'b1;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_NEXT  = 2'd2
    } req_t;

    typedef enum logic [KIND_BITS-1:0] {
        MOVE_RAPID     = 2'd0,
        MOVE_PLUNGE    = 2'd1,
        MOVE_NONE_LEFT = 2'd2,
        MOVE_FULL      = 2'd3
    } move_kind_t;

    typedef enum logic [2:0] {
        OSEL_FULL,
        OSEL_NONE,
        OSEL_RAPID_UP,
        OSEL_PLUNGE,
        OSEL_RAPID_OUT
    } out_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FULL,
        ST_NONE,
        ST_RAPID_UP,
        ST_PLUNGE,
        ST_RAPID_OUT
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     clear;
        logic     add;
        logic     scan_start;
        logic     take;
        logic     load;
        out_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic scan_busy;
        logic found;
        logic out_free;
    } status_t;

endpackage

>>> hdl/drill_hit_nearest_order.sv
`timescale 1ns / 1ps

// Greedy nearest-hit drill ordering. A clear, or an add into a table with room, is done as
// it is accepted; an add into a full table gives a full word. A next request reads the hit
// table through its single read port, one entry per cycle, then drains a four-stage distance
// pipeline (read, difference, square, compare); a full table holds 64 hits. If a free hit is
// found, its three move words then leave one per cycle through the output register while the
// receiver is ready; else a single none-left word leaves. The block works on one request at a
// time and takes the next one while the last word of the previous request still waits.
// Nothing needs clearing after reset: the block comes out of reset idle and ready.
module drill_hit_nearest_order (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dhno_pkg::REQ_BITS-1:0]   s_req_type,
    input  dhno_pkg::coord_t                s_hit_x,
    input  dhno_pkg::coord_t                s_hit_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dhno_pkg::KIND_BITS-1:0]  m_move_kind,
    output dhno_pkg::coord_t                m_pos_x,
    output dhno_pkg::coord_t                m_pos_y,
    output dhno_pkg::coord_t                m_pos_z,
    output logic [dhno_pkg::SLOT_BITS-1:0]  m_hit_slot,
    output logic                            m_run_end,
    input  logic                            cfg_wr_en,
    input  logic [dhno_pkg::CFG_BITS-1:0]   cfg_index,
    input  dhno_pkg::coord_t                cfg_wdata
);

    dhno_pkg::cmd_t    cmd;
    dhno_pkg::status_t sts;

    dhno_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .sts        (sts),
        .cmd        (cmd)
    );

    dhno_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_hit_x     (s_hit_x),
        .s_hit_y     (s_hit_y),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_move_kind (m_move_kind),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_pos_z     (m_pos_z),
        .m_hit_slot  (m_hit_slot),
        .m_run_end   (m_run_end)
    );

    // a pending word is never overwritten
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> sts.out_free)
        else $error("result word overwritten");

    // a hit is only taken after a finished search that found one
    a_take_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> (sts.found && !sts.scan_busy))
        else $error("take without a found hit");

    // no store into a full table
    a_add_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add |-> !sts.full)
        else $error("store into full table");

    // no new request while a search runs
    a_scan_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.scan_busy |-> !s_ready)
        else $error("request accepted during search");

endmodule

>>> hdl/dhno_ctrl.sv
`timescale 1ns / 1ps

module dhno_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [dhno_pkg::REQ_BITS-1:0]  s_req_type,
    input  dhno_pkg::status_t              sts,
    output dhno_pkg::cmd_t                 cmd
);

    dhno_pkg::state_t state_reg;
    dhno_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dhno_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.accept     = 1'b0;
        cmd.clear      = 1'b0;
        cmd.add        = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.take       = 1'b0;
        cmd.load       = 1'b0;
        cmd.sel        = dhno_pkg::OSEL_NONE;
        case (state_reg)
            dhno_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    case (s_req_type)
                        dhno_pkg::REQ_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        dhno_pkg::REQ_ADD: begin
                            if (sts.full) begin
                                state_next = dhno_pkg::ST_FULL;
                            end else begin
                                cmd.add = 1'b1;
                            end
                        end
                        dhno_pkg::REQ_NEXT: begin
                            cmd.scan_start = 1'b1;
                            state_next     = dhno_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dhno_pkg::ST_SCAN: begin
                if (!sts.scan_busy) begin
                    if (sts.found) begin
                        cmd.take   = 1'b1;
                        state_next = dhno_pkg::ST_RAPID_UP;
                    end else begin
                        state_next = dhno_pkg::ST_NONE;
                    end
                end
            end
            dhno_pkg::ST_FULL: begin
                cmd.sel = dhno_pkg::OSEL_FULL;
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = dhno_pkg::ST_IDLE;
                end
            end
            dhno_pkg::ST_NONE: begin
                cmd.sel = dhno_pkg::OSEL_NONE;
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = dhno_pkg::ST_IDLE;
                end
            end
            dhno_pkg::ST_RAPID_UP: begin
                cmd.sel = dhno_pkg::OSEL_RAPID_UP;
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = dhno_pkg::ST_PLUNGE;
                end
            end
            dhno_pkg::ST_PLUNGE: begin
                cmd.sel = dhno_pkg::OSEL_PLUNGE;
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = dhno_pkg::ST_RAPID_OUT;
                end
            end
            dhno_pkg::ST_RAPID_OUT: begin
                cmd.sel = dhno_pkg::OSEL_RAPID_OUT;
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = dhno_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dhno_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/dhno_dpath.sv
`timescale 1ns / 1ps

module dhno_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dhno_pkg::coord_t                s_hit_x,
    input  dhno_pkg::coord_t                s_hit_y,
    input  logic                            cfg_wr_en,
    input  logic [dhno_pkg::CFG_BITS-1:0]   cfg_index,
    input  dhno_pkg::coord_t                cfg_wdata,
    input  dhno_pkg::cmd_t                  cmd,
    output dhno_pkg::status_t               sts,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dhno_pkg::KIND_BITS-1:0]  m_move_kind,
    output dhno_pkg::coord_t                m_pos_x,
    output dhno_pkg::coord_t                m_pos_y,
    output dhno_pkg::coord_t                m_pos_z,
    output logic [dhno_pkg::SLOT_BITS-1:0]  m_hit_slot,
    output logic                            m_run_end
);

    localparam int SB = dhno_pkg::SLOT_BITS;
    localparam int CB = dhno_pkg::COUNT_BITS;

    // hit table
    dhno_pkg::coord_t mem_x [dhno_pkg::MAX_HITS];
    dhno_pkg::coord_t mem_y [dhno_pkg::MAX_HITS];
    logic [dhno_pkg::MAX_HITS-1:0] taken_reg;

    logic [CB-1:0]    count_reg;
    dhno_pkg::coord_t cur_x_reg;
    dhno_pkg::coord_t cur_y_reg;
    dhno_pkg::coord_t safe_reg;
    dhno_pkg::coord_t depth_reg;
    dhno_pkg::coord_t hold_x_reg;
    dhno_pkg::coord_t hold_y_reg;

    // scan pipeline
    logic             scan_act_reg;
    logic [CB-1:0]    scan_idx_reg;
    logic [CB-1:0]    scan_idx_next;
    logic             p1_vld_reg;
    logic             p1_skip_reg;
    logic [SB-1:0]    p1_idx_reg;
    dhno_pkg::coord_t rd_x_reg;
    dhno_pkg::coord_t rd_y_reg;
    logic             p2_vld_reg;
    logic [SB-1:0]    p2_idx_reg;
    dhno_pkg::coord_t p2_x_reg;
    dhno_pkg::coord_t p2_y_reg;
    logic signed [dhno_pkg::DIFF_BITS-1:0] dx_reg;
    logic signed [dhno_pkg::DIFF_BITS-1:0] dy_reg;
    logic             p3_vld_reg;
    logic [SB-1:0]    p3_idx_reg;
    dhno_pkg::coord_t p3_x_reg;
    dhno_pkg::coord_t p3_y_reg;
    logic [dhno_pkg::SQ_BITS-1:0] sq_x_reg;
    logic [dhno_pkg::SQ_BITS-1:0] sq_y_reg;
    logic signed [2*dhno_pkg::DIFF_BITS-1:0] prod_x;
    logic signed [2*dhno_pkg::DIFF_BITS-1:0] prod_y;
    logic [dhno_pkg::DIST_BITS-1:0] dist_sum;
    logic             found_reg;
    logic [SB-1:0]    best_idx_reg;
    logic [dhno_pkg::DIST_BITS-1:0] best_d_reg;
    dhno_pkg::coord_t best_x_reg;
    dhno_pkg::coord_t best_y_reg;

    // result word
    logic                            out_vld_reg;
    logic [dhno_pkg::KIND_BITS-1:0]  out_kind_reg;
    dhno_pkg::coord_t                out_x_reg;
    dhno_pkg::coord_t                out_y_reg;
    dhno_pkg::coord_t                out_z_reg;
    logic [SB-1:0]                   out_slot_reg;
    logic                            out_end_reg;

    assign sts.full      = (count_reg == CB'(dhno_pkg::MAX_HITS));
    assign sts.scan_busy = scan_act_reg | p1_vld_reg | p2_vld_reg | p3_vld_reg;
    assign sts.found     = found_reg;
    assign sts.out_free  = !out_vld_reg || m_ready;

    assign scan_idx_next = scan_idx_reg + CB'(1);

    always_ff @(posedge aclk) begin
        if (cmd.add) begin
            mem_x[count_reg[SB-1:0]] <= s_hit_x;
            mem_y[count_reg[SB-1:0]] <= s_hit_y;
        end
        rd_x_reg <= mem_x[scan_idx_reg[SB-1:0]];
        rd_y_reg <= mem_y[scan_idx_reg[SB-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg <= '0;
            count_reg <= '0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end else if (cmd.clear) begin
            taken_reg <= '0;
            count_reg <= '0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end else if (cmd.add) begin
            taken_reg[count_reg[SB-1:0]] <= 1'b0;
            count_reg                    <= count_reg + CB'(1);
        end else if (cmd.take) begin
            taken_reg[best_idx_reg] <= 1'b1;
            cur_x_reg               <= best_x_reg;
            cur_y_reg               <= best_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            safe_reg  <= dhno_pkg::SAFE_HEIGHT_RESET;
            depth_reg <= dhno_pkg::DRILL_DEPTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dhno_pkg::CFG_SAFE_HEIGHT: safe_reg  <= cfg_wdata;
                dhno_pkg::CFG_DRILL_DEPTH: depth_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            hold_x_reg <= s_hit_x;
            hold_y_reg <= s_hit_y;
        end
    end

    // control of the scan pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_act_reg <= 1'b0;
            scan_idx_reg <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p3_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
                scan_act_reg <= (count_reg != '0);
            end else if (scan_act_reg) begin
                scan_idx_reg <= scan_idx_next;
                if (scan_idx_next == count_reg) begin
                    scan_act_reg <= 1'b0;
                end
            end
            p1_vld_reg <= scan_act_reg;
            p2_vld_reg <= p1_vld_reg && !p1_skip_reg;
            p3_vld_reg <= p2_vld_reg;
            if (cmd.scan_start) begin
                found_reg <= 1'b0;
            end else if (p3_vld_reg && (!found_reg || dist_sum < best_d_reg)) begin
                found_reg <= 1'b1;
            end
        end
    end

    assign prod_x   = dx_reg * dx_reg;
    assign prod_y   = dy_reg * dy_reg;
    assign dist_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

    always_ff @(posedge aclk) begin
        p1_idx_reg  <= scan_idx_reg[SB-1:0];
        p1_skip_reg <= taken_reg[scan_idx_reg[SB-1:0]];
        p2_idx_reg  <= p1_idx_reg;
        p2_x_reg    <= rd_x_reg;
        p2_y_reg    <= rd_y_reg;
        dx_reg      <= {rd_x_reg[dhno_pkg::COORD_BITS-1], rd_x_reg}
                     - {cur_x_reg[dhno_pkg::COORD_BITS-1], cur_x_reg};
        dy_reg      <= {rd_y_reg[dhno_pkg::COORD_BITS-1], rd_y_reg}
                     - {cur_y_reg[dhno_pkg::COORD_BITS-1], cur_y_reg};
        p3_idx_reg  <= p2_idx_reg;
        p3_x_reg    <= p2_x_reg;
        p3_y_reg    <= p2_y_reg;
        sq_x_reg    <= prod_x[dhno_pkg::SQ_BITS-1:0];
        sq_y_reg    <= prod_y[dhno_pkg::SQ_BITS-1:0];
        // strict compare keeps the lowest index on ties
        if (p3_vld_reg && (!found_reg || dist_sum < best_d_reg)) begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= p3_idx_reg;
            best_x_reg   <= p3_x_reg;
            best_y_reg   <= p3_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.load) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            case (cmd.sel)
                dhno_pkg::OSEL_FULL: begin
                    out_kind_reg <= dhno_pkg::MOVE_FULL;
                    out_x_reg    <= hold_x_reg;
                    out_y_reg    <= hold_y_reg;
                    out_z_reg    <= '0;
                    out_slot_reg <= '0;
                    out_end_reg  <= 1'b1;
                end
                dhno_pkg::OSEL_RAPID_UP: begin
                    out_kind_reg <= dhno_pkg::MOVE_RAPID;
                    out_x_reg    <= cur_x_reg;
                    out_y_reg    <= cur_y_reg;
                    out_z_reg    <= safe_reg;
                    out_slot_reg <= best_idx_reg;
                    out_end_reg  <= 1'b0;
                end
                dhno_pkg::OSEL_PLUNGE: begin
                    out_kind_reg <= dhno_pkg::MOVE_PLUNGE;
                    out_x_reg    <= cur_x_reg;
                    out_y_reg    <= cur_y_reg;
                    out_z_reg    <= depth_reg;
                    out_slot_reg <= best_idx_reg;
                    out_end_reg  <= 1'b0;
                end
                dhno_pkg::OSEL_RAPID_OUT: begin
                    out_kind_reg <= dhno_pkg::MOVE_RAPID;
                    out_x_reg    <= cur_x_reg;
                    out_y_reg    <= cur_y_reg;
                    out_z_reg    <= safe_reg;
                    out_slot_reg <= best_idx_reg;
                    out_end_reg  <= 1'b1;
                end
                default: begin
                    out_kind_reg <= dhno_pkg::MOVE_NONE_LEFT;
                    out_x_reg    <= '0;
                    out_y_reg    <= '0;
                    out_z_reg    <= '0;
                    out_slot_reg <= '0;
                    out_end_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_move_kind = out_kind_reg;
    assign m_pos_x     = out_x_reg;
    assign m_pos_y     = out_y_reg;
    assign m_pos_z     = out_z_reg;
    assign m_hit_slot  = out_slot_reg;
    assign m_run_end   = out_end_reg;

endmodule

>>> verif/drill_hit_nearest_order_tb.sv
`timescale 1ns / 1ps

module drill_hit_nearest_order_tb;
    import dhno_pkg::*;

    typedef logic [REQ_BITS-1:0] req_code_t;

    localparam req_code_t REQ_UNUSED = 2'd3;
    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam int unsigned PHASE_ITEMS  = 60;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct {
        req_code_t rq;
        coord_t    x;
        coord_t    y;
    } drill_req_t;

    typedef struct {
        logic [KIND_BITS-1:0] kind;
        coord_t               x;
        coord_t               y;
        coord_t               z;
        logic [SLOT_BITS-1:0] slot;
        logic                 last;
    } move_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    req_code_t             s_req_type = REQ_CLEAR;
    coord_t                s_hit_x = '0;
    coord_t                s_hit_y = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [KIND_BITS-1:0]  m_move_kind;
    coord_t                m_pos_x;
    coord_t                m_pos_y;
    coord_t                m_pos_z;
    logic [SLOT_BITS-1:0]  m_hit_slot;
    logic                  m_run_end;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]   cfg_index = CFG_SAFE_HEIGHT;
    coord_t                cfg_wdata = '0;

    drill_hit_nearest_order uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_hit_x     (s_hit_x),
        .s_hit_y     (s_hit_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_move_kind (m_move_kind),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_pos_z     (m_pos_z),
        .m_hit_slot  (m_hit_slot),
        .m_run_end   (m_run_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    // shadow of the hit table and tool point
    coord_t      hit_tab_x [MAX_HITS];
    coord_t      hit_tab_y [MAX_HITS];
    bit          hit_taken [MAX_HITS];
    int unsigned hit_count = 0;
    coord_t      tool_x = '0;
    coord_t      tool_y = '0;
    coord_t      safe_z = SAFE_HEIGHT_RESET;
    coord_t      depth_z = DRILL_DEPTH_RESET;

    drill_req_t  pending_reqs[$];
    move_word_t  expected_moves[$];
    drill_req_t  next_req;
    move_word_t  front_word;

    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned counted_items = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned cycles = 0;
    int unsigned error_count = 0;
    int unsigned words_checked = 0;
    int unsigned n_clear = 0, n_add = 0, n_next = 0, n_ignored = 0;
    int unsigned n_full = 0, n_none = 0;
    bit          no_idle = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic coord_t pick_coord(int unsigned style);
        case (style)
            0: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return coord_t'(0);
                    3: return coord_t'(-1);
                    default: return coord_t'(1);
                endcase
            end
            // tight cluster so that distance ties are common
            1: return coord_t'(int'($urandom_range(0, 8)) - 4);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic move_word_t make_word(logic [KIND_BITS-1:0] kind, coord_t x, coord_t y,
                                             coord_t z, logic [SLOT_BITS-1:0] slot,
                                             logic last);
        move_word_t w;
        w.kind = kind;
        w.x = x;
        w.y = y;
        w.z = z;
        w.slot = slot;
        w.last = last;
        return w;
    endfunction

    task automatic predict_request(req_code_t rq, coord_t hx, coord_t hy);
        longint dx, dy, d2, best_d2;
        int best;
        bit found;
        best = 0;
        best_d2 = 0;
        found = 1'b0;
        case (rq)
            REQ_CLEAR: begin
                for (int i = 0; i < MAX_HITS; i++) hit_taken[i] = 1'b0;
                hit_count = 0;
                tool_x = '0;
                tool_y = '0;
                n_clear++;
            end
            REQ_ADD: begin
                n_add++;
                if (hit_count >= MAX_HITS) begin
                    expected_moves.push_back(make_word(MOVE_FULL, hx, hy, '0, '0, 1'b1));
                    n_full++;
                end else begin
                    hit_tab_x[hit_count] = hx;
                    hit_tab_y[hit_count] = hy;
                    hit_taken[hit_count] = 1'b0;
                    hit_count++;
                end
            end
            REQ_NEXT: begin
                n_next++;
                for (int i = 0; i < hit_count; i++) begin
                    if (!hit_taken[i]) begin
                        dx = longint'(hit_tab_x[i]) - longint'(tool_x);
                        dy = longint'(hit_tab_y[i]) - longint'(tool_y);
                        d2 = dx * dx + dy * dy;
                        if (!found || d2 < best_d2) begin
                            found = 1'b1;
                            best = i;
                            best_d2 = d2;
                        end
                    end
                end
                if (!found) begin
                    expected_moves.push_back(make_word(MOVE_NONE_LEFT, '0, '0, '0, '0, 1'b1));
                    n_none++;
                end else begin
                    hit_taken[best] = 1'b1;
                    tool_x = hit_tab_x[best];
                    tool_y = hit_tab_y[best];
                    expected_moves.push_back(make_word(MOVE_RAPID, tool_x, tool_y, safe_z,
                                                       SLOT_BITS'(best), 1'b0));
                    expected_moves.push_back(make_word(MOVE_PLUNGE, tool_x, tool_y, depth_z,
                                                       SLOT_BITS'(best), 1'b0));
                    expected_moves.push_back(make_word(MOVE_RAPID, tool_x, tool_y, safe_z,
                                                       SLOT_BITS'(best), 1'b1));
                end
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic report_error(string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic signed [63:0] got, logic signed [63:0] want);
        if (got !== want)
            report_error($sformatf("word %0d %s got %0d expected %0d",
                                   words_checked, name, got, want));
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_request(s_req_type, s_hit_x, s_hit_y);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    s_req_type <= next_req.rq;
                    s_hit_x <= next_req.x;
                    s_hit_y <= next_req.y;
                    s_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // move word monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_moves.size() == 0) begin
                    report_error($sformatf("unexpected word kind %0d at (%0d, %0d, %0d)",
                                           m_move_kind, m_pos_x, m_pos_y, m_pos_z));
                end else begin
                    front_word = expected_moves.pop_front();
                    check_field("move_kind", m_move_kind, front_word.kind);
                    check_field("pos_x", m_pos_x, front_word.x);
                    check_field("pos_y", m_pos_y, front_word.y);
                    check_field("pos_z", m_pos_z, front_word.z);
                    check_field("hit_slot", m_hit_slot, front_word.slot);
                    check_field("run_end", m_run_end, front_word.last);
                end
                words_checked++;
            end
            if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ((m_valid && m_ready) || $urandom_range(0, 15) == 0)
                    recv_stall <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, expected_moves.size());
            $display("drill_hit_nearest_order test failed");
            $finish;
        end
    end

    task automatic queue_req(req_code_t rq, coord_t x, coord_t y);
        drill_req_t r;
        r.rq = rq;
        r.x = x;
        r.y = y;
        pending_reqs.push_back(r);
        queued_count++;
        if (rq != REQ_UNUSED) counted_items++;
    endtask

    task automatic wait_idle();
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < DRAIN_CYCLES) begin
            @(posedge aclk);
            if (queued_count != accepted_count || expected_moves.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    endtask

    task automatic set_heights(coord_t safe, coord_t depth);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SAFE_HEIGHT;
        cfg_wdata <= safe;
        @(posedge aclk);
        cfg_index <= CFG_DRILL_DEPTH;
        cfg_wdata <= depth;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        safe_z = safe;
        depth_z = depth;
    endtask

    task automatic queue_noise();
        queue_req(req_code_t'($urandom_range(0, 3)), pick_coord(2), pick_coord(2));
    endtask

    // fill past capacity so the full status shows up
    task automatic fill_table();
        int unsigned style;
        queue_req(REQ_CLEAR, pick_coord(2), pick_coord(2));
        for (int k = 0; k < MAX_HITS + 3; k++) begin
            style = $urandom_range(0, 2);
            queue_req(REQ_ADD, pick_coord(style), pick_coord(style));
        end
        for (int k = 0; k < 4; k++) queue_req(REQ_NEXT, pick_coord(2), pick_coord(2));
        queue_req(REQ_ADD, pick_coord(2), pick_coord(2));
    endtask

    task automatic gen_sequence();
        int unsigned style, n_adds, n_nexts;
        style = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) != 0) queue_req(REQ_CLEAR, pick_coord(2), pick_coord(2));
        n_adds = $urandom_range(1, 10);
        for (int k = 0; k < n_adds; k++) begin
            queue_req(REQ_ADD, pick_coord(style), pick_coord(style));
            if ($urandom_range(0, 9) == 0) queue_noise();
        end
        n_nexts = $urandom_range(n_adds / 2, n_adds + 2);
        for (int k = 0; k < n_nexts; k++) begin
            queue_req(REQ_NEXT, pick_coord(2), pick_coord(2));
            if ($urandom_range(0, 9) == 0) queue_noise();
        end
    endtask

    initial begin
        int unsigned goal;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extremes, ties, ignored type, clear back to origin
        queue_req(REQ_NEXT, '0, '0);
        queue_req(REQ_UNUSED, COORD_MAX, COORD_MIN);
        queue_req(REQ_ADD, COORD_MAX, COORD_MAX);
        queue_req(REQ_ADD, COORD_MIN, COORD_MIN);
        queue_req(REQ_ADD, coord_t'(0), coord_t'(0));
        queue_req(REQ_ADD, coord_t'(-1), coord_t'(1));
        queue_req(REQ_ADD, coord_t'(1), coord_t'(-1));
        repeat (6) queue_req(REQ_NEXT, COORD_MIN, COORD_MAX);
        queue_req(REQ_ADD, COORD_MAX, COORD_MIN);
        queue_req(REQ_ADD, COORD_MIN, COORD_MAX);
        queue_req(REQ_NEXT, '0, '0);
        queue_req(REQ_NEXT, '0, '0);
        queue_req(REQ_CLEAR, COORD_MAX, COORD_MAX);
        queue_req(REQ_NEXT, '0, '0);
        queue_req(REQ_ADD, coord_t'(3), coord_t'(4));
        queue_req(REQ_ADD, coord_t'(-3), coord_t'(-4));
        queue_req(REQ_NEXT, '0, '0);
        queue_req(REQ_CLEAR, '0, '0);
        queue_req(REQ_ADD, coord_t'(5), coord_t'(5));
        queue_req(REQ_NEXT, '0, '0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_heights(COORD_MAX, COORD_MIN);
                1: set_heights(COORD_MIN, COORD_MAX);
                default: set_heights(coord_t'($urandom), coord_t'($urandom));
            endcase
            if (phase == 1) fill_table();
            goal = counted_items + PHASE_ITEMS;
            while (counted_items < goal) gen_sequence();
        end
        no_idle = 1'b0;
        wait_idle();

        $display("sent %0d requests: %0d clears, %0d adds, %0d nexts, %0d ignored",
                 accepted_count, n_clear, n_add, n_next, n_ignored);
        $display("checked %0d move words incl. %0d full drops and %0d empty-table replies",
                 words_checked, n_full, n_none);
        if (error_count == 0) begin
            $display("drill_hit_nearest_order test passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("drill_hit_nearest_order test failed");
        end
        $finish;
    end

endmodule
